// ===== src/lzwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared constants and types for the variable-width LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;
  localparam int DictCodes  = 4096;
  localparam int MaxString  = 64;
  localparam int CodeW      = $clog2(DictCodes) + 1;   // holds the null code
  localparam int AddrW      = $clog2(DictCodes);
  localparam int StackW     = $clog2(MaxString);
  localparam int WidthW     = $clog2(CodeW + 1);
  localparam logic [CodeW-1:0] NullCode = CodeW'(DictCodes);

  localparam logic [1:0] StatData     = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatWrongCode = 2'd2;

  // One dictionary entry: prefix code and appended byte.
  typedef struct packed {
    logic [CodeW-1:0] prefix;
    logic [7:0]       data;
  } entry_t;
endpackage

// ===== src/lzw_variable_width_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variable-width decoder
// Unpacks MSB-first codes from a byte stream and emits decoded strings.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata bits                       tuser
// s_axis   in   [7:0] in_byte                    -
// m_axis   out  [7:0] out_byte                   [1:0] status
//                tlast = last_of_string
// A byte that completes no code is simply taken. A code walks its chain
// at one dictionary read per cycle (registered RAM read), then its string
// is output through the string stack.
// Output stalls hold the emit phase; no new byte is taken until it ends.
// Reset clears control state only; root entries come from address decoding.
// After an error the block drops all input until reset.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder
  import lzwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // last_of_string
  output logic [1:0] m_axis_tuser    // [1:0] status
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_WALK = 5'b00100,
    S_EMIT = 5'b01000,
    S_HALT = 5'b10000
  } state_t;

  state_t            state;
  logic [23:0]       bit_buffer;
  logic [4:0]        bits_held;
  logic [CodeW-1:0]  prev_code, highest, code;
  logic [7:0]        prev_first;
  logic [WidthW-1:0] code_width;
  logic [7:0]        stack [MaxString];
  logic [StackW-1:0] depth, rd_ptr;
  logic              new_entry;    // a dictionary add goes with this code
  entry_t            rd_entry;
  logic              rd_en, wr_en;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  entry_t            wr_entry;

  logic [23:0]       buf_next;
  logic [4:0]        held_next;
  logic [CodeW-1:0]  code_next;
  logic [CodeW-1:0]  slot;
  logic [CodeW-1:0]  hi_next;
  logic              out_ok;
  logic              have_code;
  logic              full_err, wrong_err, err_fire;
  logic              emit_fire, last_pos;
  logic              kwk, grow, wrap;

  assign slot      = highest + CodeW'(1);
  assign buf_next  = {bit_buffer[15:0], s_axis_tdata};
  assign held_next = bits_held + 5'd8 - 5'(code_width);
  always_comb begin
    logic [23:0] sh;
    sh        = buf_next >> held_next;
    code_next = CodeW'(sh[15:0] & ((16'd1 << code_width) - 16'd1));
  end

  lzwd_dict u_dict (
    .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_entry(rd_entry),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_entry(wr_entry)
  );

  assign out_ok        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ((state == S_IDLE) && out_ok) || (state == S_HALT);
  assign have_code     = (bits_held + 5'd8 >= 5'(code_width));
  assign wrong_err     = (code_next > highest) && (code_next != slot);
  assign full_err      = (prev_code != NullCode) && (slot >= NullCode) &&
                         ((code_next <= highest) || (code_next == slot));
  assign err_fire      = (state == S_IDLE) && s_axis_tvalid && out_ok && have_code &&
                         (full_err || wrong_err);

  // The KwKwK string is the previous string plus its own first byte, so the
  // walk starts at the previous code after pushing that byte.
  assign kwk     = (code == slot);
  assign rd_en   = (state == S_READ) || (state == S_WALK);
  assign rd_addr = (state == S_READ) ? ((kwk && new_entry) ? prev_code[AddrW-1:0]
                                                           : code[AddrW-1:0])
                                     : rd_entry.prefix[AddrW-1:0];

  assign emit_fire = (state == S_EMIT) && out_ok;
  assign last_pos  = (rd_ptr == StackW'(MaxString - 1));

  // The KwKwK pair is added before its walk; a normal pair once the first
  // byte of the new string is known, at the end of the emit phase.
  assign wr_en          = new_entry && (((state == S_READ) && kwk) ||
                                        (emit_fire && last_pos && !kwk));
  assign wr_addr        = slot[AddrW-1:0];
  assign wr_entry.prefix = prev_code;
  assign wr_entry.data  = prev_first;

  assign hi_next = new_entry ? slot : highest;
  assign grow    = (hi_next + CodeW'(1) == (CodeW'(1) << code_width));
  assign wrap    = (hi_next + CodeW'(1) == NullCode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bit_buffer    <= '0;
      bits_held     <= '0;
      prev_code     <= NullCode;
      prev_first    <= '0;
      highest       <= CodeW'(255);
      code_width    <= WidthW'(8);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_fire || err_fire) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && out_ok) begin
            bit_buffer <= buf_next;
            if (have_code) begin
              bits_held <= held_next;
              code      <= code_next;
              new_entry <= (prev_code != NullCode);
              if (full_err || wrong_err) begin
                m_axis_tdata <= '0;
                m_axis_tlast <= 1'b0;
                m_axis_tuser <= wrong_err ? StatWrongCode : StatFull;
                state        <= S_HALT;
              end else begin
                state <= S_READ;
              end
            end else begin
              bits_held <= bits_held + 5'd8;
            end
          end
        end
        S_READ: begin
          if (new_entry && kwk) begin
            stack[StackW'(MaxString - 1)] <= prev_first;
            depth <= StackW'(1);
          end else begin
            depth <= '0;
          end
          state <= S_WALK;
        end
        S_WALK: begin
          // rd_entry holds the entry addressed last cycle.
          stack[StackW'(MaxString - 1) - depth] <= rd_entry.data;
          depth <= depth + 1'b1;
          if (rd_entry.prefix == NullCode || depth == StackW'(MaxString - 1)) begin
            rd_ptr     <= StackW'(MaxString - 1) - depth;
            prev_first <= rd_entry.data;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ok) begin
            m_axis_tdata <= stack[rd_ptr];
            m_axis_tuser <= StatData;
            m_axis_tlast <= last_pos;
            if (last_pos) begin
              prev_code <= wrap ? NullCode : code;
              highest   <= wrap ? CodeW'(255) : hi_next;
              if (wrap) code_width <= WidthW'(8);
              else if (grow) code_width <= code_width + 1'b1;
              state <= S_IDLE;
            end else begin
              rd_ptr <= rd_ptr + 1'b1;
            end
          end
        end
        S_HALT: ;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/lzwd_dict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW dictionary memory
// Entries above 255 live in a one-read, one-write RAM with registered read.
// Root entries are synthesized from the address, so no preload is needed.
// ----------------------------------------------------------------------------
module lzwd_dict
  import lzwd_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output entry_t           rd_entry,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  entry_t           wr_entry
);
  entry_t           mem [DictCodes];
  entry_t           ram_q;
  logic             root_q;
  logic [7:0]       root_byte_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      ram_q       <= mem[rd_addr];
      root_q      <= (rd_addr < AddrW'(256));
      root_byte_q <= rd_addr[7:0];
    end
  end

  always_comb begin
    if (root_q) begin
      rd_entry.prefix = NullCode;
      rd_entry.data   = root_byte_q;
    end else begin
      rd_entry = ram_q;
    end
  end
endmodule

// ===== bench/tb_lzw_variable_width_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variable-width decoder testbench
// Packs legal code streams (roots, known codes, KwKwK codes) into bytes,
// decodes them with an in-bench dictionary model and checks every output
// transaction. Ends on a wrong code.
// ----------------------------------------------------------------------------
module tb_lzw_variable_width_decoder;
  import lzwd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] stat;
  } out_item_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  lzw_variable_width_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  logic [7:0]  byte_q[$];
  out_item_t   decoded_q[$];
  int          bytes_sent;
  int          drain_point;
  int          cycle_cnt;
  int          mismatches;
  bit          failed;

  // Decoder model state.
  logic [CodeW-1:0] dict_prefix[DictCodes];
  logic [7:0]       dict_byte[DictCodes];
  logic [23:0]      bit_buf;
  int               bits_in_buf;
  int               last_code;
  logic [7:0]       last_first;
  int               top_code;
  int               cur_width;
  bit               stopped;

  // Stream packer and legal-code tracker used while building the stimulus.
  logic [31:0] pack_acc;
  int          pack_bits;
  int          gen_top;
  int          gen_width;
  bit          gen_no_prev;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void model_reset();
    for (int i = 0; i < 256; i++) begin
      dict_prefix[i] = NullCode;
      dict_byte[i]   = 8'(i);
    end
    bit_buf     = '0;
    bits_in_buf = 0;
    last_code   = DictCodes;
    last_first  = '0;
    top_code    = 255;
    cur_width   = 8;
    stopped     = 1'b0;
  endfunction

  function automatic void push_error(logic [1:0] st);
    out_item_t r;
    r.data = '0;
    r.last = 1'b0;
    r.stat = st;
    decoded_q.push_back(r);
    stopped = 1'b1;
  endfunction

  // Walks the chain of code, keeps at most the final MaxString bytes and
  // queues them; returns the first kept byte.
  function automatic logic [7:0] expand_code(int code);
    logic [7:0] chars[MaxString];
    int         n;
    int         c;
    out_item_t  r;
    n = 0;
    c = code;
    while (c < DictCodes && n < MaxString) begin
      chars[MaxString-1-n] = dict_byte[c];
      c = int'(dict_prefix[c]);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      r.data = chars[MaxString-n+k];
      r.last = (k == n - 1);
      r.stat = StatData;
      decoded_q.push_back(r);
    end
    return (n > 0) ? chars[MaxString-n] : 8'd0;
  endfunction

  // Returns 1 when the dictionary cannot take another entry.
  function automatic bit add_word(int prefix, logic [7:0] b);
    if (prefix >= DictCodes) return 1'b0;
    if (top_code + 1 >= DictCodes) return 1'b1;
    top_code++;
    dict_prefix[top_code] = CodeW'(prefix);
    dict_byte[top_code]   = b;
    return 1'b0;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int code;
    if (stopped) return;
    bit_buf = {bit_buf[15:0], b};
    bits_in_buf += 8;
    if (bits_in_buf < cur_width) return;
    bits_in_buf -= cur_width;
    code = int'((bit_buf >> bits_in_buf) & ((24'd1 << cur_width) - 24'd1));
    if (code <= top_code) begin
      if (last_code < DictCodes && top_code + 1 >= DictCodes) begin
        push_error(StatFull);
        return;
      end
      last_first = expand_code(code);
      void'(add_word(last_code, last_first));
    end else begin
      if (code != top_code + 1) begin
        push_error(StatWrongCode);
        return;
      end
      if (add_word(last_code, last_first)) begin
        push_error(StatFull);
        return;
      end
      last_first = expand_code(code);
    end
    last_code = code;
    if (top_code + 1 == (1 << cur_width)) cur_width++;
    if (top_code + 1 == DictCodes) begin
      last_code = DictCodes;
      top_code  = 255;
      cur_width = 8;
    end
  endfunction

  function automatic void pack_code(int code, int w);
    pack_acc = (pack_acc << w) | 32'(code);
    pack_bits += w;
    while (pack_bits >= 8) begin
      byte_q.push_back(8'(pack_acc >> (pack_bits - 8)));
      pack_bits -= 8;
    end
  endfunction

  // Packs one code at the tracked width and follows the decoder's growth.
  function automatic bit send_code(int code);
    pack_code(code, gen_width);
    if (!gen_no_prev) gen_top++;
    gen_no_prev = 1'b0;
    if (gen_top + 1 == (1 << gen_width)) gen_width++;
    if (gen_top + 1 == DictCodes) begin
      gen_top     = 255;
      gen_width   = 8;
      gen_no_prev = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_code();
    int r;
    r = $urandom_range(99);
    if (!gen_no_prev && r < 10) return gen_top + 1;
    if (r < 40) return $urandom_range(255);
    return $urandom_range(gen_top);
  endfunction

  function automatic bit take_break();
    if (cycle_cnt >= 800 && cycle_cnt < 1600) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  // Input driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      bytes_sent    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && !take_break() &&
            !(bytes_sent == drain_point && decoded_q.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_q.pop_front();
          bytes_sent    <= bytes_sent + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      cycle_cnt     <= 0;
    end else begin
      cycle_cnt     <= cycle_cnt + 1;
      m_axis_tready <= !take_break();
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected transaction: data %02h last %0d status %0d",
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          want = decoded_q.pop_front();
          if (want.data !== m_axis_tdata || want.last !== m_axis_tlast ||
              want.stat !== m_axis_tuser) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected data %02h last %0d status %0d, got %02h %0d %0d",
                       want.data, want.last, want.stat,
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
          end
        end
      end
    end
  end

  initial begin
    int directed[];
    directed      = '{0, 255, 255, 0, 128, 1, 170, 85, 254};
    failed        = 1'b0;
    mismatches    = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    pack_acc      = '0;
    pack_bits     = 0;
    gen_top       = 255;
    gen_width     = 8;
    gen_no_prev   = 1'b1;
    model_reset();

    foreach (directed[i]) void'(send_code(directed[i]));
    void'(send_code(255));
    drain_point = byte_q.size();
    // Random legal codes.
    while (byte_q.size() < 225)
      void'(send_code(pick_code()));
    // A wrong code needs room above the next free entry.
    while (gen_width < 9 || gen_top + 2 >= (1 << gen_width))
      void'(send_code(pick_code()));
    pack_code((1 << gen_width) - 1, gen_width);
    if (pack_bits != 0) pack_code(0, 8 - pack_bits);
    repeat (3) byte_q.push_back(8'($urandom_range(255)));

    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (byte_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
